/* rtl/tsur_pkg.sv */
package tsur_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int DATA_BITS   = 8;

	localparam int THRESH_W = 12;
	localparam int COUNT_W  = 16;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int BYTE_W   = 8;
	localparam int BIT_IDX_W = 3;

	localparam logic [THRESH_W-1:0] THRESH_RESET  = THRESH_W'(3900);
	localparam logic [COUNT_W-1:0]  TPB_RESET     = COUNT_W'(16);
	localparam logic [COUNT_W-1:0]  TIMEOUT_RESET = COUNT_W'(30000);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LINE_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_BIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT   = 2'd2;

	// last data bit position
	localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(DATA_BITS - 1);

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_START = 3'd1,
		PH_HALF  = 3'd2,
		PH_DATA  = 3'd3,
		PH_STOP  = 3'd4,
		PH_TAIL  = 3'd5
	} phase_t;

endpackage

/* rtl/threshold_sampled_uart_receiver.sv */
// Serial byte receiver working from converter samples of the receive line, one sample per
// request. A sample above line_threshold reads as line high. While idle and high the block
// counts samples and, once the count passes idle_timeout, delivers a timeout request
// (data_byte zero, timed_out set) and starts counting again. A low sample opens a frame:
// after one and a half bit times (ticks_per_bit samples each) eight data bits are taken
// LSB first one bit time apart, the stop bit one bit time later, and half a bit after that
// the byte is delivered with the stop level for information only - a low stop bit is not
// rejected. Every wait lasts at least one sample. Throughput is one sample per clock: the
// sample is registered, the frame state and its counters are updated by a single pass of
// logic, and any result lands in an output register. The input side stalls only while
// a sample is held in the input register and the output register holds an untaken result
// that is itself stalled. Configuration is written through cfg_write/cfg_index/cfg_data;
// the user must write it only while idle; the block itself does not enforce this.
module threshold_sampled_uart_receiver (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_write,
	input  logic [tsur_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tsur_pkg::CFG_W-1:0]         cfg_data,
	// sample requests
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [tsur_pkg::SAMPLE_BITS-1:0]   sample,
	// result requests
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [tsur_pkg::BYTE_W-1:0]        data_byte,
	output logic                               timed_out,
	output logic                               stop_level
);
	import tsur_pkg::*;

	// configuration registers
	logic [THRESH_W-1:0] line_threshold_q;
	logic [COUNT_W-1:0]  ticks_per_bit_q;
	logic [COUNT_W-1:0]  idle_timeout_q;

	// input stage
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;

	// frame state
	phase_t               phase_q, phase_d;
	logic [COUNT_W-1:0]   tick_count_q, tick_count_d;
	logic [BIT_IDX_W-1:0] bit_index_q, bit_index_d;
	logic [BYTE_W-1:0]    shift_byte_q, shift_byte_d;
	logic [COUNT_W-1:0]   idle_count_q, idle_count_d;
	logic                 stop_seen_q, stop_seen_d;

	// result register
	logic              out_valid_q;
	logic [BYTE_W-1:0] data_byte_q;
	logic              timed_out_q;
	logic              stop_level_q;

	// step results
	logic              emit;
	logic [BYTE_W-1:0] emit_byte;
	logic              emit_timeout;
	logic              emit_stop;

	logic               advance;
	logic               line_high;
	logic [COUNT_W-1:0] half_bit;
	logic [COUNT_W-1:0] wait_len;
	logic [COUNT_W-1:0] tick_inc;
	logic               wait_end;
	logic [COUNT_W:0]   idle_inc;

	// the held sample moves on unless the result register is full and stalled
	assign advance  = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && (out_valid_q && out_stall);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_threshold_q <= THRESH_RESET;
			ticks_per_bit_q  <= TPB_RESET;
			idle_timeout_q   <= TIMEOUT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_LINE_THRESHOLD: line_threshold_q <= cfg_data[THRESH_W-1:0];
				REG_TICKS_PER_BIT:  ticks_per_bit_q  <= cfg_data;
				REG_IDLE_TIMEOUT:   idle_timeout_q   <= cfg_data;
				default:            ;
			endcase
		end
	end

	// input register: valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// input register: payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sample_s1 <= sample;
		end
	end

	// threshold slicer and shared wait counter
	assign line_high = sample_s1 > line_threshold_q;
	assign half_bit  = ticks_per_bit_q >> 1;
	assign wait_len  = (phase_q == PH_HALF || phase_q == PH_TAIL) ? half_bit : ticks_per_bit_q;
	assign tick_inc  = tick_count_q + COUNT_W'(1);
	// a zero length or a counter wrap also ends the wait
	assign wait_end  = (tick_inc >= wait_len) || (tick_inc == '0);
	assign idle_inc  = {1'b0, idle_count_q} + (COUNT_W+1)'(1);

	// next frame state for the held sample
	always_comb begin
		phase_d      = phase_q;
		tick_count_d = tick_count_q;
		bit_index_d  = bit_index_q;
		shift_byte_d = shift_byte_q;
		idle_count_d = idle_count_q;
		stop_seen_d  = stop_seen_q;
		emit         = 1'b0;
		emit_byte    = '0;
		emit_timeout = 1'b0;
		emit_stop    = 1'b0;

		unique case (phase_q)
			PH_IDLE: begin
				if (line_high) begin
					if (idle_inc > {1'b0, idle_timeout_q}) begin
						idle_count_d = '0;
						emit         = 1'b1;
						emit_timeout = 1'b1;
					end else begin
						idle_count_d = idle_inc[COUNT_W-1:0];
					end
				end else begin
					// start bit edge
					idle_count_d = '0;
					tick_count_d = '0;
					bit_index_d  = '0;
					shift_byte_d = '0;
					stop_seen_d  = 1'b0;
					phase_d      = PH_START;
				end
			end
			PH_START: begin
				tick_count_d = wait_end ? '0 : tick_inc;
				if (wait_end) begin
					phase_d = PH_HALF;
				end
			end
			PH_HALF, PH_DATA: begin
				tick_count_d = wait_end ? '0 : tick_inc;
				if (wait_end) begin
					// the half wait always lands on data bit zero
					if (phase_q == PH_HALF) begin
						shift_byte_d[0] = shift_byte_q[0] | line_high;
						bit_index_d     = BIT_IDX_W'(1);
						phase_d         = PH_DATA;
					end else begin
						shift_byte_d[bit_index_q] = shift_byte_q[bit_index_q] | line_high;
						if (bit_index_q >= LAST_BIT) begin
							bit_index_d = '0;
							phase_d     = PH_STOP;
						end else begin
							bit_index_d = bit_index_q + BIT_IDX_W'(1);
							phase_d     = PH_DATA;
						end
					end
				end
			end
			PH_STOP: begin
				tick_count_d = wait_end ? '0 : tick_inc;
				if (wait_end) begin
					stop_seen_d = line_high;
					phase_d     = PH_TAIL;
				end
			end
			PH_TAIL: begin
				tick_count_d = wait_end ? '0 : tick_inc;
				if (wait_end) begin
					phase_d      = PH_IDLE;
					idle_count_d = '0;
					emit         = 1'b1;
					emit_byte    = shift_byte_q;
					emit_stop    = stop_seen_q;
				end
			end
			default: begin
				phase_d      = PH_IDLE;
				tick_count_d = '0;
			end
		endcase
	end

	// frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			tick_count_q <= '0;
			bit_index_q  <= '0;
			shift_byte_q <= '0;
			idle_count_q <= '0;
			stop_seen_q  <= 1'b0;
		end else if (advance) begin
			phase_q      <= phase_d;
			tick_count_q <= tick_count_d;
			bit_index_q  <= bit_index_d;
			shift_byte_q <= shift_byte_d;
			idle_count_q <= idle_count_d;
			stop_seen_q  <= stop_seen_d;
		end
	end

	// result register: valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register: payload
	always_ff @(posedge clk) begin
		if (advance && emit) begin
			data_byte_q  <= emit_byte;
			timed_out_q  <= emit_timeout;
			stop_level_q <= emit_stop;
		end
	end

	assign out_valid  = out_valid_q;
	assign data_byte  = data_byte_q;
	assign timed_out  = timed_out_q;
	assign stop_level = stop_level_q;

	// a timeout result carries no byte and no stop level
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && timed_out |-> data_byte == '0 && !stop_level)
		else $error("timeout result carries byte data");

	// the idle counter stays clear for the whole of a frame
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_IDLE |-> idle_count_q == '0)
		else $error("idle count running inside a frame");

	// a non-zero bit position only exists while data bits are being taken
	assert property (@(posedge clk) disable iff (!arst_n)
		bit_index_q != '0 |-> phase_q == PH_DATA)
		else $error("bit index outside data phase");

	// the input side only stalls behind a full, stalled result register
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without back pressure");

	// a stalled result is never dropped
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(data_byte_q))
		else $error("stalled result lost");

endmodule

/* sim/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tsur_pkg::*;

	// one result request as the receiver should deliver it
	typedef struct packed {
		logic [BYTE_W-1:0] data_b;
		logic              tmo_flag;
		logic              stop_b;
	} rx_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_write;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]       cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	logic [SAMPLE_BITS-1:0] sample;
	logic                   out_valid;
	logic                   out_stall;
	logic [BYTE_W-1:0]      data_byte;
	logic                   timed_out;
	logic                   stop_level;

	threshold_sampled_uart_receiver DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.data_byte  (data_byte),
		.timed_out  (timed_out),
		.stop_level (stop_level)
	);

	// 10 ns clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// register copies as the receiver should hold them
	logic [THRESH_W-1:0] cfg_thr;
	logic [COUNT_W-1:0]  cfg_tpb;
	logic [COUNT_W-1:0]  cfg_tmo;

	// frame state of the receiver as predicted
	phase_t              pr_phase;
	logic [COUNT_W-1:0]  pr_ticks;
	logic [BIT_IDX_W-1:0] pr_bit;
	logic [BYTE_W-1:0]   pr_shift;
	logic [COUNT_W-1:0]  pr_idle;
	logic                pr_stop;

	// results still owed by the receiver, oldest first
	rx_result_t pending_results[$];

	int  errors;
	int  n_samples;
	int  n_bytes_due;
	int  n_timeouts_due;
	int  n_checked;
	int  n_settings;
	bit  tx_quiet;
	bit  rx_quiet;
	int  stall_left;

	// wait before the next request on either side: mostly none, otherwise a random wait
	function automatic int draw_wait(input bit quiet);
		if (quiet)
			return 0;
		if ($urandom_range(0, 2) == 0)
			return $urandom_range(1, 12);
		return 0;
	endfunction

	// bit-time counter, every wait lasts at least one tick even for a length of zero
	function automatic bit wait_elapsed(input logic [COUNT_W-1:0] len);
		pr_ticks = pr_ticks + 1'b1;
		if (pr_ticks >= len || pr_ticks == '0) begin
			pr_ticks = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// lsb-first shift of one data bit, moving on to the stop bit after the last
	function automatic void shift_in(input bit hi);
		if (hi)
			pr_shift[pr_bit] = 1'b1;
		if (pr_bit == LAST_BIT) begin
			pr_bit   = '0;
			pr_phase = PH_STOP;
		end else begin
			pr_bit   = pr_bit + 1'b1;
			pr_phase = PH_DATA;
		end
	endfunction

	// advance the predicted receiver by one accepted sample and queue any result it owes
	function automatic void predict_uart_rx(input logic [SAMPLE_BITS-1:0] s);
		bit                 hi;
		logic [COUNT_W-1:0] half;
		logic [COUNT_W:0]   nxt;
		hi   = s > cfg_thr;
		half = cfg_tpb >> 1;
		case (pr_phase)
			PH_IDLE: begin
				if (hi) begin
					// compared one bit wider so that the largest timeout still fires
					nxt = {1'b0, pr_idle} + 1'b1;
					if (nxt > {1'b0, cfg_tmo}) begin
						pr_idle = '0;
						pending_results.push_back('{data_b: '0, tmo_flag: 1'b1, stop_b: 1'b0});
						n_timeouts_due++;
					end else begin
						pr_idle = nxt[COUNT_W-1:0];
					end
				end else begin
					pr_idle  = '0;
					pr_ticks = '0;
					pr_bit   = '0;
					pr_shift = '0;
					pr_stop  = 1'b0;
					pr_phase = PH_START;
				end
			end
			PH_START: begin
				if (wait_elapsed(cfg_tpb))
					pr_phase = PH_HALF;
			end
			PH_HALF: begin
				if (wait_elapsed(half)) begin
					pr_bit = '0;
					shift_in(hi);
				end
			end
			PH_DATA: begin
				if (wait_elapsed(cfg_tpb))
					shift_in(hi);
			end
			PH_STOP: begin
				if (wait_elapsed(cfg_tpb)) begin
					pr_stop  = hi;
					pr_phase = PH_TAIL;
				end
			end
			PH_TAIL: begin
				// a low stop bit is reported, never rejected
				if (wait_elapsed(half)) begin
					pr_phase = PH_IDLE;
					pr_idle  = '0;
					pending_results.push_back('{data_b: pr_shift, tmo_flag: 1'b0, stop_b: pr_stop});
					n_bytes_due++;
				end
			end
			default: begin
				pr_phase = PH_IDLE;
				pr_ticks = '0;
			end
		endcase
	endfunction

	// converter value that reads as the wanted line level under the current threshold
	function automatic logic [SAMPLE_BITS-1:0] level_sample(input bit hi);
		if (!hi)
			return SAMPLE_BITS'($urandom_range(0, cfg_thr));
		if (cfg_thr == {THRESH_W{1'b1}})
			return SAMPLE_BITS'($urandom_range(0, 4095));
		return SAMPLE_BITS'($urandom_range(cfg_thr + 1, 4095));
	endfunction

	// one sample request: optional gap, then hold until accepted
	task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
		int gap;
		gap = draw_wait(tx_quiet);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_uart_rx(s);
		n_samples++;
	endtask

	// line held high for n ticks
	task automatic idle_run(input int n);
		repeat (n) send_sample(level_sample(1'b1));
	endtask

	// start bit, data lsb first, stop bit, each one bit time long; nbits below 10 cuts it short
	task automatic send_frame(input logic [7:0] b, input bit stop_hi, input int glitch_pct,
			input int nbits);
		int         bl;
		logic [9:0] line_bits;
		bit         lv;
		bl        = (cfg_tpb < 2) ? 1 : int'(cfg_tpb);
		line_bits = {stop_hi, b, 1'b0};
		for (int k = 0; k < nbits; k++) begin
			for (int t = 0; t < bl; t++) begin
				lv = line_bits[k];
				if ($urandom_range(0, 99) < glitch_pct)
					lv = !lv;
				send_sample(level_sample(lv));
			end
		end
		idle_run($urandom_range(1, 3));
	endtask

	// stop sending and wait until every owed result has come, plus the pipeline latency
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// feed high samples until the predicted receiver is back in idle, then drain
	task automatic settle();
		while (pr_phase != PH_IDLE)
			send_sample({SAMPLE_BITS{1'b1}});
		drain();
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		case (idx)
			REG_LINE_THRESHOLD: cfg_thr = value[THRESH_W-1:0];
			REG_TICKS_PER_BIT:  cfg_tpb = value;
			REG_IDLE_TIMEOUT:   cfg_tmo = value;
			default: ;
		endcase
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// new register setting, only ever with the receiver idle and nothing owed
	task automatic set_config(input int thr, input int tpb, input int tmo);
		settle();
		write_reg(REG_LINE_THRESHOLD, CFG_W'(thr));
		write_reg(REG_TICKS_PER_BIT, CFG_W'(tpb));
		write_reg(REG_IDLE_TIMEOUT, CFG_W'(tmo));
		n_settings++;
	endtask

	// receiver side: draws a stall length after each taken result, counting down every cycle
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			stall_left = draw_wait(rx_quiet);
		else if (stall_left > 0)
			stall_left--;
		out_stall <= (stall_left != 0);
	end

	// every taken result is compared against the oldest owed one
	always @(posedge clk) begin
		rx_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: data %02h timed_out %0b stop_level %0b",
						data_byte, timed_out, stop_level);
			end else begin
				want = pending_results.pop_front();
				if (data_byte !== want.data_b || timed_out !== want.tmo_flag ||
						stop_level !== want.stop_b) begin
					errors++;
					if (errors <= 10) begin
						$display("result %0d mismatch: expected data %02h timed_out %0b stop_level %0b",
							n_checked, want.data_b, want.tmo_flag, want.stop_b);
						$display("  got data %02h timed_out %0b stop_level %0b",
							data_byte, timed_out, stop_level);
					end
				end
			end
			n_checked++;
		end
	end

	// reset values: threshold edge at 3900, then a frame at the default 16 ticks per bit
	task automatic test_reset_values();
		send_sample(12'd4095);
		send_sample(12'd3901);
		send_sample(12'd3900);
		settle();
	endtask

	// bit times of zero and one wait a single tick, two gives a half bit of one tick
	task automatic test_short_bit_times();
		set_config(2000, 0, 30000);
		send_frame(8'hA5, 1'b1, 0, 10);
		set_config(2000, 1, 30000);
		send_frame(8'h5A, 1'b1, 0, 10);
		set_config(2000, 2, 30000);
		send_frame(8'h00, 1'b1, 0, 10);
		send_frame(8'hFF, 1'b1, 0, 10);
	endtask

	// threshold zero: only a zero sample is low; threshold at full scale: the line never reads high
	task automatic test_threshold_extremes();
		set_config(0, 3, 30000);
		send_sample(12'd1);
		send_frame(8'h81, 1'b1, 0, 10);
		set_config(4095, 2, 30000);
		repeat (24) send_sample(12'd4095);
	endtask

	// a low stop bit still delivers the byte
	task automatic test_stop_bit_low();
		set_config(1000, 4, 30000);
		send_frame(8'h3C, 1'b0, 0, 10);
	endtask

	// short timeouts repeat while the line stays high; a frame clears the count
	task automatic test_idle_timeouts();
		set_config(2048, 4, 1);
		idle_run(6);
		send_frame(8'hC3, 1'b1, 0, 10);
		idle_run(5);
		set_config(2048, 2, 3);
		idle_run(9);
	endtask

	// largest timeout: a frame, then a high idle run well short of it stays silent
	task automatic test_idle_timeout_max();
		set_config(2048, 2, 65535);
		send_frame(BYTE_W'($urandom_range(0, 255)), 1'b1, 0, 10);
		idle_run(40);
		drain();
	endtask

	// largest bit time, only while idle
	task automatic test_long_bit_time();
		set_config(2048, 65535, 65535);
		idle_run(20);
	endtask

	// rounds of random settings, mostly clean frames, with noise, cut frames and idle runs
	task automatic test_random_traffic();
		int s0;
		int r0;
		int thr;
		int tpb;
		int tmo;
		s0 = n_samples;
		r0 = n_bytes_due + n_timeouts_due;
		while (n_samples - s0 < 120 || n_bytes_due + n_timeouts_due - r0 < 12) begin
			case ($urandom_range(0, 9))
				0:       thr = 0;
				1:       thr = 4095;
				default: thr = $urandom_range(200, 3900);
			endcase
			case ($urandom_range(0, 9))
				0:       tpb = $urandom_range(0, 1);
				1:       tpb = $urandom_range(7, 20);
				default: tpb = $urandom_range(2, 5);
			endcase
			case ($urandom_range(0, 3))
				0:       tmo = 30000;
				1:       tmo = $urandom_range(1, 4);
				default: tmo = $urandom_range(5, 40);
			endcase
			set_config(thr, tpb, tmo);
			// some rounds run flat out on one or both sides
			tx_quiet = ($urandom_range(0, 4) == 0);
			rx_quiet = ($urandom_range(0, 4) == 0);
			repeat ($urandom_range(2, 6)) begin
				case ($urandom_range(0, 9))
					0: repeat ($urandom_range(1, 8))
						send_sample(SAMPLE_BITS'($urandom_range(0, 4095)));
					1: send_frame(BYTE_W'($urandom_range(0, 255)), 1'b1, 0,
						$urandom_range(1, 9));
					2: idle_run($urandom_range(1, 60));
					default: send_frame(BYTE_W'($urandom_range(0, 255)),
						$urandom_range(0, 3) != 0, ($urandom_range(0, 4) == 0) ? 3 : 0, 10);
				endcase
				// sender holds off now and then until everything owed has come
				if ($urandom_range(0, 7) == 0)
					drain();
			end
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	initial begin
		arst_n    <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= REG_LINE_THRESHOLD;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		sample    <= '0;
		tx_quiet   = 1'b0;
		rx_quiet   = 1'b0;
		cfg_thr    = THRESH_RESET;
		cfg_tpb    = TPB_RESET;
		cfg_tmo    = TIMEOUT_RESET;
		pr_phase   = PH_IDLE;
		pr_ticks   = '0;
		pr_bit     = '0;
		pr_shift   = '0;
		pr_idle    = '0;
		pr_stop    = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_short_bit_times();
		test_threshold_extremes();
		test_stop_bit_low();
		test_idle_timeouts();
		test_idle_timeout_max();
		test_long_bit_time();
		test_random_traffic();

		drain();
		$display("%0d samples sent over %0d register settings", n_samples, n_settings);
		$display("%0d results checked: %0d bytes, %0d timeouts", n_checked, n_bytes_due,
			n_timeouts_due);
		if (errors == 0 && pending_results.size() == 0)
			$display("** threshold_sampled_uart_receiver: PASSED **");
		else
			$display("** threshold_sampled_uart_receiver: FAILED **");
		$finish;
	end

	// hang guard, far beyond the slowest correct run
	initial begin
		#20_000_000;
		$display("** threshold_sampled_uart_receiver: FAILED **");
		$finish;
	end

endmodule
